@@ design/rpd_pkg.sv @@
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int PACKETS_PER_FRAME_DEF = 4;
  localparam int CHANNEL_COUNT_DEF     = 8;

  localparam int SYM_W   = 10;
  localparam int VAL_W   = 6;
  localparam int POS_W   = 16;
  localparam int ABS_W   = 10;
  localparam int DELTA_W = 4;
  localparam int AUX_W   = 2;
  localparam int CHECK_W = 8;
  localparam int PAIR_W  = 2;

  // Signed offset applied to the 4-bit delta field.
  localparam int DELTA_BIAS = 8;

  // Line code: entry i is the 10-bit symbol that carries value i.
  localparam logic [SYM_W-1:0] CODE_TABLE [64] = '{
    10'h3F8, 10'h3F3, 10'h3E3, 10'h3E7, 10'h3C7, 10'h3CF, 10'h38F, 10'h39F,
    10'h0FF, 10'h07F, 10'h03F, 10'h33F, 10'h31F, 10'h30F, 10'h387, 10'h3C3,
    10'h0FC, 10'h0F3, 10'h0E7, 10'h0CF, 10'h3CC, 10'h39C, 10'h33C, 10'h333,
    10'h3F0, 10'h3E0, 10'h383, 10'h307, 10'h31C, 10'h398, 10'h38C, 10'h338,
    10'h0C7, 10'h073, 10'h067, 10'h0E3, 10'h0F8, 10'h07C, 10'h01F, 10'h00F,
    10'h0CC, 10'h0C3, 10'h063, 10'h033, 10'h330, 10'h318, 10'h30C, 10'h303,
    10'h03C, 10'h078, 10'h0F0, 10'h0E0, 10'h0C0, 10'h3C0, 10'h380, 10'h300,
    10'h060, 10'h070, 10'h030, 10'h038, 10'h018, 10'h01C, 10'h00C, 10'h007
  };

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] val;
  } dec_t;

  // Packet command handed from the symbol front end to the update engine.
  typedef struct packed {
    logic [PAIR_W-1:0]  pair;
    logic               half;
    logic               err;
    logic [AUX_W-1:0]   aux;
    logic [DELTA_W-1:0] delta;
    logic [ABS_W-1:0]   position;
    logic [CHECK_W-1:0] check;
    logic               frame_done;
  } cmd_t;

  typedef struct packed {
    logic [PAIR_W-1:0]  pair;
    logic [POS_W-1:0]   even_pos;
    logic [POS_W-1:0]   odd_pos;
    logic               err;
    logic [AUX_W-1:0]   aux;
    logic [CHECK_W-1:0] check;
    logic               frame_done;
  } res_t;

  function automatic dec_t decode_symbol(logic [SYM_W-1:0] sym);
    dec_t r;
    r.hit = 1'b0;
    r.val = '0;
    for (int i = 0; i < 64; i++) begin
      if (CODE_TABLE[i] == sym) begin
        r.hit = 1'b1;
        r.val = VAL_W'(i);
      end
    end
    return r;
  endfunction

  // Reduce a channel number below 16 modulo m (m >= 2).
  function automatic logic [3:0] chan_mod(logic [3:0] v, int m);
    logic [3:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= 4'(m)) r = r - 4'(m);
    end
    return r;
  endfunction

endpackage

@@ design/rpd_front.sv @@
`timescale 1ns / 1ps

module rpd_front import rpd_pkg::*; #(
  parameter int PACKETS_PER_FRAME = PACKETS_PER_FRAME_DEF,
  parameter int CHANNEL_COUNT     = CHANNEL_COUNT_DEF,
  parameter int CH_W              = $clog2(CHANNEL_COUNT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [SYM_W-1:0] symbol_word,
  input  logic             invert_polarity,
  input  logic             second_half,
  input  logic             frame_start,
  output logic             push,
  output cmd_t             cmd,
  output logic [CH_W-1:0]  even_ch,
  output logic [CH_W-1:0]  odd_ch
);

  localparam int PC_W = $clog2(PACKETS_PER_FRAME + 1);

  logic [1:0]       symbol_count;
  logic [PC_W-1:0]  packet_count;
  logic             error_seen;
  logic [VAL_W-1:0] sym_buf [3];

  logic [1:0]       sc_eff;
  logic [PC_W-1:0]  pc_eff;
  logic             es_eff;
  logic             active;
  logic             err_now;
  logic [3:0]       pc4;
  dec_t             dec;

  always_comb begin
    sc_eff  = frame_start ? 2'd0 : symbol_count;
    pc_eff  = frame_start ? '0 : packet_count;
    es_eff  = frame_start ? 1'b0 : error_seen;
    active  = pc_eff < PC_W'(PACKETS_PER_FRAME);
    dec     = decode_symbol(invert_polarity ? ~symbol_word : symbol_word);
    err_now = es_eff | ~dec.hit;
    pc4     = 4'(pc_eff);
    push    = accept && active && (sc_eff == 2'd3);

    cmd.pair       = pc4[1:0];
    cmd.half       = second_half;
    cmd.err        = err_now;
    cmd.aux        = sym_buf[0][5:4];
    cmd.delta      = sym_buf[0][3:0];
    cmd.position   = {sym_buf[1], sym_buf[2][5:2]};
    cmd.check      = {sym_buf[2][1:0], dec.val};
    cmd.frame_done = pc_eff == PC_W'(PACKETS_PER_FRAME - 1);

    even_ch = CH_W'(chan_mod({pc4[2:0], 1'b0}, CHANNEL_COUNT));
    odd_ch  = CH_W'(chan_mod({pc4[2:0], 1'b1}, CHANNEL_COUNT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= 2'd0;
      packet_count <= PC_W'(PACKETS_PER_FRAME);
      error_seen   <= 1'b0;
    end else if (accept && active) begin
      if (sc_eff == 2'd3) begin
        symbol_count <= 2'd0;
        packet_count <= pc_eff + PC_W'(1);
        error_seen   <= 1'b0;
      end else begin
        symbol_count <= sc_eff + 2'd1;
        packet_count <= pc_eff;
        error_seen   <= err_now;
      end
    end
  end

  // Hold the first three values of the packet.
  always_ff @(posedge clk) begin
    if (accept && active && (sc_eff != 2'd3)) begin
      sym_buf[sc_eff] <= dec.val;
    end
  end

endmodule

@@ design/rpd_queue.sv @@
`timescale 1ns / 1ps

module rpd_queue import rpd_pkg::*; #(
  parameter int CH_W = $clog2(CHANNEL_COUNT_DEF)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cmd_t            in_cmd,
  input  logic [CH_W-1:0] in_even,
  input  logic [CH_W-1:0] in_odd,
  output logic            out_valid,
  input  logic            out_ready,
  output cmd_t            out_cmd,
  output logic [CH_W-1:0] out_even,
  output logic [CH_W-1:0] out_odd
);

  localparam logic [1:0] FULL_COUNT = 2'd2;

  cmd_t            cmd_q  [2];
  logic [CH_W-1:0] even_q [2];
  logic [CH_W-1:0] odd_q  [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign in_ready  = count != FULL_COUNT;
  assign out_valid = count != 2'd0;
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;
  assign out_cmd   = cmd_q[rd_ptr];
  assign out_even  = even_q[rd_ptr];
  assign out_odd   = odd_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q[wr_ptr]  <= in_cmd;
      even_q[wr_ptr] <= in_even;
      odd_q[wr_ptr]  <= in_odd;
    end
  end

endmodule

@@ design/rpd_back.sv @@
`timescale 1ns / 1ps

module rpd_back import rpd_pkg::*; #(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int CH_W          = $clog2(CHANNEL_COUNT)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  cmd_t            q_cmd,
  input  logic [CH_W-1:0] q_even,
  input  logic [CH_W-1:0] q_odd,
  output logic            res_valid,
  input  logic            res_ready,
  output res_t            res
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DEL,
    B_POS
  } state_t;

  state_t           state;
  cmd_t             cmd_r;
  logic [CH_W-1:0]  even_r;
  logic [CH_W-1:0]  odd_r;
  logic [POS_W-1:0] del_new;

  logic [POS_W-1:0]         mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] vld;
  logic [POS_W-1:0]         rd_data;

  logic             wr_en;
  logic [CH_W-1:0]  wr_addr;
  logic [POS_W-1:0] wr_data;
  logic             rd_en;
  logic [CH_W-1:0]  rd_addr;
  logic             out_load;
  logic [CH_W-1:0]  pos_head;
  logic [CH_W-1:0]  del_head;
  logic [CH_W-1:0]  pos_r;
  logic [CH_W-1:0]  del_r;
  logic [POS_W-1:0] del_sum;

  always_comb begin
    pos_head = q_cmd.half ? q_odd : q_even;
    del_head = q_cmd.half ? q_even : q_odd;
    pos_r    = cmd_r.half ? odd_r : even_r;
    del_r    = cmd_r.half ? even_r : odd_r;
    del_sum  = rd_data + POS_W'(cmd_r.delta) - POS_W'(DELTA_BIAS);

    q_ready  = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = pos_head;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = del_head;
    out_load = 1'b0;

    unique case (state)
      B_IDLE: begin
        // Write the absolute value, fetch the old delta channel.
        q_ready = 1'b1;
        if (q_valid) begin
          rd_en   = 1'b1;
          rd_addr = del_head;
          wr_en   = ~q_cmd.err;
          wr_addr = pos_head;
          wr_data = POS_W'(q_cmd.position);
        end
      end
      B_DEL: begin
        // Write the adjusted channel, fetch the absolute channel back.
        rd_en   = 1'b1;
        rd_addr = pos_r;
        wr_en   = ~cmd_r.err;
        wr_addr = del_r;
        wr_data = del_sum;
      end
      B_POS: begin
        out_load = !res_valid || res_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
  end

  // A channel never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (out_load)       res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;

      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            cmd_r  <= q_cmd;
            even_r <= q_even;
            odd_r  <= q_odd;
            state  <= B_DEL;
          end
        end
        B_DEL: begin
          del_new <= cmd_r.err ? rd_data : del_sum;
          state   <= B_POS;
        end
        B_POS: begin
          if (out_load) begin
            res.pair       <= cmd_r.pair;
            res.even_pos   <= cmd_r.half ? del_new : rd_data;
            res.odd_pos    <= cmd_r.half ? rd_data : del_new;
            res.err        <= cmd_r.err;
            res.aux        <= cmd_r.err ? '0 : cmd_r.aux;
            res.check      <= cmd_r.err ? '0 : cmd_r.check;
            res.frame_done <= cmd_r.frame_done;
            state          <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/rc_pcm_frame_decoder.sv @@
`timescale 1ns / 1ps

// Decoder for a ten-to-six PCM line code: takes one 10-bit symbol per cycle,
// groups four symbols into a packet and updates one channel pair per packet,
// emitting the pair's positions after the update (tlast on the last packet of
// a frame, tuser set on an errored packet). Symbols are accepted every cycle
// as long as the two-entry packet queue has room; each packet then passes
// through the update engine, bound by its registered-read channel store, in
// the steps fetch and absolute write, adjusted write and read back, output
// load, and the engine takes no new packet before the last result is loaded
// to the output. The channel store reads as zero after reset at once,
// without a clearing pass.
module rc_pcm_frame_decoder import rpd_pkg::*; #(
  parameter int PACKETS_PER_FRAME = PACKETS_PER_FRAME_DEF,
  parameter int CHANNEL_COUNT     = CHANNEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // symbol_word[9:0], zero
  input  logic [2:0]  s_tuser,   // invert_polarity, second_half, frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pair_index, even_position, odd_position,
                                 // aux_bits, check_byte, zero
  output logic [0:0]  m_tuser,   // packet_error
  output logic        m_tlast
);

  localparam int CH_W = $clog2(CHANNEL_COUNT);
  localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(PACKETS_PER_FRAME - 1);

  logic            accept;
  logic            push;
  logic            push_ready;
  cmd_t            f_cmd;
  logic [CH_W-1:0] f_even;
  logic [CH_W-1:0] f_odd;
  logic            q_valid;
  logic            q_ready;
  cmd_t            q_cmd;
  logic [CH_W-1:0] q_even;
  logic [CH_W-1:0] q_odd;
  res_t            res;

  assign s_tready = push_ready;
  assign accept   = s_tvalid && s_tready;

  rpd_front #(
    .PACKETS_PER_FRAME(PACKETS_PER_FRAME),
    .CHANNEL_COUNT    (CHANNEL_COUNT),
    .CH_W             (CH_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .symbol_word    (s_tdata[SYM_W-1:0]),
    .invert_polarity(s_tuser[0]),
    .second_half    (s_tuser[1]),
    .frame_start    (s_tuser[2]),
    .push           (push),
    .cmd            (f_cmd),
    .even_ch        (f_even),
    .odd_ch         (f_odd)
  );

  rpd_queue #(
    .CH_W(CH_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push),
    .in_ready (push_ready),
    .in_cmd   (f_cmd),
    .in_even  (f_even),
    .in_odd   (f_odd),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_cmd  (q_cmd),
    .out_even (q_even),
    .out_odd  (q_odd)
  );

  rpd_back #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .CH_W         (CH_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .q_even   (q_even),
    .q_odd    (q_odd),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {4'b0, res.check, res.aux, res.odd_pos, res.even_pos, res.pair};
  assign m_tuser = res.err;
  assign m_tlast = res.frame_done;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[43:34] == 10'd0)
    else $error("errored packet carries aux or check bits");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[1:0] == PAIR_LAST)
    else $error("frame end flagged on wrong pair");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid)
    else $error("queued packet lost while engine busy");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rpd_pkg::*;

  localparam int PKTS  = PACKETS_PER_FRAME_DEF;
  localparam int CHANS = CHANNEL_COUNT_DEF;

  // Ten-to-six line code, entry i carries value i.
  localparam logic [9:0] LINE_CODE [64] = '{
    10'h3F8, 10'h3F3, 10'h3E3, 10'h3E7, 10'h3C7, 10'h3CF, 10'h38F, 10'h39F,
    10'h0FF, 10'h07F, 10'h03F, 10'h33F, 10'h31F, 10'h30F, 10'h387, 10'h3C3,
    10'h0FC, 10'h0F3, 10'h0E7, 10'h0CF, 10'h3CC, 10'h39C, 10'h33C, 10'h333,
    10'h3F0, 10'h3E0, 10'h383, 10'h307, 10'h31C, 10'h398, 10'h38C, 10'h338,
    10'h0C7, 10'h073, 10'h067, 10'h0E3, 10'h0F8, 10'h07C, 10'h01F, 10'h00F,
    10'h0CC, 10'h0C3, 10'h063, 10'h033, 10'h330, 10'h318, 10'h30C, 10'h303,
    10'h03C, 10'h078, 10'h0F0, 10'h0E0, 10'h0C0, 10'h3C0, 10'h380, 10'h300,
    10'h060, 10'h070, 10'h030, 10'h038, 10'h018, 10'h01C, 10'h00C, 10'h007
  };

  typedef struct {
    logic [9:0] word;
    logic       inv;
    logic       half;
    logic       start;
  } line_symbol_t;

  typedef struct {
    logic [1:0]  pair;
    logic [15:0] even_pos;
    logic [15:0] odd_pos;
    logic        err;
    logic [1:0]  aux;
    logic [7:0]  check;
    logic        frame_done;
  } pair_update_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // symbol_word[9:0], zero
  logic [2:0]  s_tuser = '0;   // invert_polarity, second_half, frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // pair_index, even_position, odd_position,
                               // aux_bits, check_byte, zero
  logic [0:0]  m_tuser;        // packet_error
  logic        m_tlast;

  line_symbol_t symbol_q[$];
  pair_update_t predicted_pairs[$];
  int           mismatch_count = 0;

  // decoder shadow state
  logic [1:0]  sym_cnt = '0;
  int          pkt_cnt = PKTS;
  logic [5:0]  sym_buf [3];
  logic        err_seen = 1'b0;
  logic [15:0] chan_pos [CHANS];

  rc_pcm_frame_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic int code_index(logic [9:0] w);
    int idx;
    idx = -1;
    for (int i = 0; i < 64; i++) begin
      if (LINE_CODE[i] == w) idx = i;
    end
    return idx;
  endfunction

  // Word as it arrives on the line, so that decode after polarity gives value v.
  function automatic logic [9:0] code_word(int v, logic inv);
    return inv ? ~LINE_CODE[v] : LINE_CODE[v];
  endfunction

  function automatic logic [9:0] bad_word(logic inv);
    logic [9:0] w;
    w = 10'($urandom);
    while (code_index(w) >= 0) w = 10'($urandom);
    return inv ? ~w : w;
  endfunction

  task automatic add_sym(logic [9:0] w, logic inv, logic half, logic start);
    line_symbol_t s;
    s.word  = w;
    s.inv   = inv;
    s.half  = half;
    s.start = start;
    symbol_q.push_back(s);
  endtask

  task automatic update_channel_model(line_symbol_t s);
    logic [9:0]   w;
    int           idx;
    logic [5:0]   v;
    logic [3:0]   delta;
    logic [15:0]  position;
    int           even_ch, odd_ch, pos_ch, del_ch;
    pair_update_t r;
    if (s.start) begin
      sym_cnt  = '0;
      pkt_cnt  = 0;
      err_seen = 1'b0;
    end
    if (pkt_cnt >= PKTS) return;
    w   = s.inv ? ~s.word : s.word;
    idx = code_index(w);
    v   = (idx < 0) ? 6'd0 : 6'(idx);
    if (idx < 0) err_seen = 1'b1;
    if (sym_cnt < 3) begin
      sym_buf[sym_cnt] = v;
      sym_cnt = sym_cnt + 2'd1;
      return;
    end
    delta    = sym_buf[0][3:0];
    position = {6'd0, sym_buf[1], sym_buf[2][5:2]};
    even_ch  = (2 * pkt_cnt) % CHANS;
    odd_ch   = (2 * pkt_cnt + 1) % CHANS;
    pos_ch   = s.half ? odd_ch : even_ch;
    del_ch   = s.half ? even_ch : odd_ch;
    if (!err_seen) begin
      chan_pos[pos_ch] = position;
      chan_pos[del_ch] = chan_pos[del_ch] + {12'd0, delta} - 16'd8;
    end
    r.pair     = 2'(pkt_cnt);
    r.even_pos = chan_pos[even_ch];
    r.odd_pos  = chan_pos[odd_ch];
    r.err      = err_seen;
    r.aux      = err_seen ? 2'd0 : sym_buf[0][5:4];
    r.check    = err_seen ? 8'd0 : {sym_buf[2][1:0], v};
    pkt_cnt    = pkt_cnt + 1;
    sym_cnt    = '0;
    err_seen   = 1'b0;
    r.frame_done = (pkt_cnt >= PKTS);
    predicted_pairs.push_back(r);
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Driver: bursts of words separated by random gaps.
  line_symbol_t cur_sym;
  int           burst_left = 0;
  int           gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) update_channel_model(cur_sym);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (symbol_q.size() > 0) begin
          cur_sym = symbol_q.pop_front();
          s_tdata  <= {6'd0, cur_sym.word};
          s_tuser  <= {cur_sym.start, cur_sym.half, cur_sym.inv};
          s_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern and result check.
  int rx_run = 0;
  int rx_stall = 0;

  always @(posedge clk) begin
    pair_update_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_pairs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          e = predicted_pairs.pop_front();
          check_field("pair_index", {14'd0, e.pair}, {14'd0, m_tdata[1:0]});
          check_field("even_position", e.even_pos, m_tdata[17:2]);
          check_field("odd_position", e.odd_pos, m_tdata[33:18]);
          check_field("aux_bits", {14'd0, e.aux}, {14'd0, m_tdata[35:34]});
          check_field("check_byte", {8'd0, e.check}, {8'd0, m_tdata[43:36]});
          check_field("packet_error", {15'd0, e.err}, {15'd0, m_tuser[0]});
          check_field("frame_done", {15'd0, e.frame_done}, {15'd0, m_tlast});
        end
      end
      if (rx_run > 0) begin
        rx_run = rx_run - 1;
        m_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall = rx_stall - 1;
        m_tready <= 1'b0;
      end else begin
        rx_run   = $urandom_range(1, 30);
        rx_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL rc_pcm_frame_decoder");
    $finish;
  end

  initial begin
    int   counted;
    int   kind;
    int   n;
    logic gen_idle;
    logic inv;
    for (int i = 0; i < CHANS; i++) chan_pos[i] = '0;
    for (int i = 0; i < 3; i++) sym_buf[i] = '0;

    // idle frame: words without frame_start are dropped
    add_sym(10'h3FF, 1'b0, 1'b0, 1'b0);
    add_sym(10'h000, 1'b1, 1'b1, 1'b0);
    // pair 0: all-ones values, largest delta and position
    add_sym(code_word(63, 1'b0), 1'b0, 1'b0, 1'b1);
    add_sym(code_word(63, 1'b1), 1'b1, 1'b0, 1'b0);
    add_sym(code_word(63, 1'b0), 1'b0, 1'b0, 1'b0);
    add_sym(code_word(63, 1'b1), 1'b1, 1'b0, 1'b0);
    // pair 1: zero values, delta wraps below zero, swapped halves
    add_sym(code_word(0, 1'b1), 1'b1, 1'b0, 1'b0);
    add_sym(code_word(0, 1'b0), 1'b0, 1'b0, 1'b0);
    add_sym(code_word(0, 1'b0), 1'b0, 1'b0, 1'b0);
    add_sym(code_word(0, 1'b1), 1'b1, 1'b1, 1'b0);
    // pair 2: unlisted words, no update
    add_sym(code_word(21, 1'b0), 1'b0, 1'b0, 1'b0);
    add_sym(10'h3FF, 1'b1, 1'b0, 1'b0);
    add_sym(10'h000, 1'b0, 1'b0, 1'b0);
    add_sym(code_word(42, 1'b0), 1'b0, 1'b1, 1'b0);
    // pair 3 closes the frame
    add_sym(code_word(42, 1'b1), 1'b1, 1'b1, 1'b0);
    add_sym(code_word(21, 1'b0), 1'b0, 1'b1, 1'b0);
    add_sym(code_word(55, 1'b1), 1'b1, 1'b1, 1'b0);
    add_sym(code_word(8, 1'b0), 1'b0, 1'b1, 1'b0);
    // restart mid-packet: drop the partial packet, begin again at pair 0
    add_sym(code_word(17, 1'b0), 1'b0, 1'b0, 1'b1);
    add_sym(code_word(33, 1'b0), 1'b0, 1'b0, 1'b0);
    add_sym(code_word(9, 1'b1), 1'b1, 1'b1, 1'b1);
    add_sym(code_word(50, 1'b0), 1'b0, 1'b0, 1'b0);
    add_sym(code_word(5, 1'b0), 1'b0, 1'b1, 1'b0);
    add_sym(code_word(62, 1'b1), 1'b1, 1'b0, 1'b0);

    counted  = 0;
    gen_idle = 1'b0;
    while (counted < 1150) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise, dropped while idle, decoded otherwise
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          add_sym(10'($urandom), 1'($urandom), 1'($urandom), 1'b0);
        if (!gen_idle) counted += n;
      end else if (kind == 1) begin
        // broken frame, may carry stray frame_start words
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++) begin
          inv = 1'($urandom);
          add_sym(($urandom_range(0, 5) == 0) ? bad_word(inv) :
                  code_word($urandom_range(0, 63), inv),
                  inv, 1'($urandom), (i == 0) || ($urandom_range(0, 9) == 0));
        end
        counted += n;
        gen_idle = 1'b0;
      end else begin
        for (int i = 0; i < 4 * PKTS; i++) begin
          inv = 1'($urandom);
          add_sym(($urandom_range(0, 15) == 0) ? bad_word(inv) :
                  code_word($urandom_range(0, 63), inv),
                  inv, 1'($urandom), i == 0);
        end
        counted += 4 * PKTS;
        gen_idle = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (symbol_q.size() != 0 || s_tvalid) @(posedge clk);
    while (predicted_pairs.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS rc_pcm_frame_decoder");
    end else begin
      $display("FAIL rc_pcm_frame_decoder");
    end
    $finish;
  end

endmodule
